// File: rtl/incremental_euler_number_defines.svh
// Assertion macros for the incremental Euler number block.
// Included by the top level; no other dependencies.
`ifndef INCREMENTAL_EULER_NUMBER_DEFINES_SVH
`define INCREMENTAL_EULER_NUMBER_DEFINES_SVH
`ifndef SYNTHESIS
`define IEN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IEN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IEN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IEN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/ien_pkg.sv
// Shared types, constants and quad weighting for the incremental Euler number block.
// No dependencies.
package ien_pkg;

  localparam int FUNC_W  = 2;
  localparam int NB_W    = 8;
  localparam int OUT_W   = 24;
  localparam int DELTA_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd2;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] FEAT_BIAS = 24'sd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_HOLD
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [OUT_W-1:0] operand;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  function automatic logic signed [2:0] quad_w(logic a, logic b, logic d, logic e);
    logic [2:0]        n;
    logic signed [2:0] w;
    n = 3'(a) + 3'(b) + 3'(d) + 3'(e);
    w = 3'sd0;
    if (n == 3'd1) begin
      w = 3'sd1;
    end else if (n == 3'd3) begin
      w = -3'sd1;
    end else if (n == 3'd2 && ((a && e) || (b && d))) begin
      w = 3'sd2;
    end
    return w;
  endfunction

  function automatic logic signed [3:0] quad_step(logic a, logic b, logic d, logic e,
                                                  int unsigned ctr);
    logic signed [2:0] w0;
    logic signed [2:0] w1;
    w0 = quad_w(a, b, d, e);
    unique case (ctr)
      0:       w1 = quad_w(1'b1, b, d, e);
      1:       w1 = quad_w(a, 1'b1, d, e);
      2:       w1 = quad_w(a, b, 1'b1, e);
      default: w1 = quad_w(a, b, d, 1'b1);
    endcase
    return 4'(w1) - 4'(w0);
  endfunction

  // Neighbour bits: 0 top-left, 1 top, 2 top-right, 3 left, 4 right,
  // 5 bottom-left, 6 bottom, 7 bottom-right; centre starts clear.
  function automatic logic signed [DELTA_W-1:0] pixel_delta(logic [NB_W-1:0] nb);
    logic signed [3:0] q_tl;
    logic signed [3:0] q_tr;
    logic signed [3:0] q_bl;
    logic signed [3:0] q_br;
    q_tl = quad_step(nb[0], nb[1], nb[3], 1'b0, 3);
    q_tr = quad_step(nb[1], nb[2], 1'b0, nb[4], 2);
    q_bl = quad_step(nb[3], 1'b0, nb[5], nb[6], 1);
    q_br = quad_step(1'b0, nb[4], nb[6], nb[7], 0);
    return DELTA_W'(q_tl) + DELTA_W'(q_tr) + DELTA_W'(q_bl) + DELTA_W'(q_br);
  endfunction

endpackage

// File: rtl/ien_front.sv
// Front end: decodes each input transaction into a queue entry.
// Depends on ien_pkg.
module ien_front (
  input  logic [ien_pkg::FUNC_W-1:0]        func_i,
  input  logic [ien_pkg::NB_W-1:0]          neighbours_i,
  input  logic signed [ien_pkg::OUT_W-1:0]  other_quarters_i,
  output ien_pkg::entry_t                   entry_o
);
  import ien_pkg::*;

  logic signed [DELTA_W-1:0] delta;

  assign delta = pixel_delta(neighbours_i);

  always_comb begin
    unique case (func_i)
      FUNC_CLEAR: begin
        entry_o.op      = OP_CLEAR;
        entry_o.operand = '0;
      end
      FUNC_ADD: begin
        entry_o.op      = OP_ADD;
        entry_o.operand = OUT_W'(delta);
      end
      FUNC_MERGE: begin
        entry_o.op      = OP_ADD;
        entry_o.operand = other_quarters_i;
      end
      default: begin
        entry_o.op      = OP_HOLD;
        entry_o.operand = '0;
      end
    endcase
  end

endmodule

// File: rtl/ien_queue.sv
// Short queue between the front end and the accumulator.
// Depends on ien_pkg.
module ien_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ien_pkg::entry_t       entry_i,
  input  logic                  pop_i,
  output ien_pkg::entry_t       entry_o,
  output ien_pkg::queue_status_t status_o
);
  import ien_pkg::*;

  entry_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o        = mem_q[rd_ptr_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));

endmodule

// File: rtl/ien_back.sv
// Back end: saturating accumulator and registered result stage.
// Depends on ien_pkg.
module ien_back #(
  parameter int ACC_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             avail_i,
  input  ien_pkg::entry_t                  entry_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ien_pkg::OUT_W-1:0] genus_quarters_o,
  output logic signed [ien_pkg::OUT_W-1:0] feature_quarters_o,
  output logic                             saturated_o
);
  import ien_pkg::*;

  localparam int SumW = ((ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W) + 1;
  localparam logic signed [SumW-1:0] AccMax = (SumW'(1) <<< (ACC_WIDTH - 1)) - SumW'(1);
  localparam logic signed [SumW-1:0] AccMin = ~AccMax;
  localparam logic signed [SumW-1:0] OutMaxX = SumW'(OUT_MAX);
  localparam logic signed [SumW-1:0] OutMinX = ~OutMaxX;
  localparam logic signed [OUT_W:0]  FeatMax = (OUT_W + 1)'(OUT_MAX);

  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic                        out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0]     genus_q, genus_d;
  logic signed [OUT_W-1:0]     feature_q, feature_d;
  logic                        sat_q, sat_d;

  logic signed [SumW-1:0]  sum_w;
  logic signed [SumW-1:0]  acc_x;
  logic signed [OUT_W:0]   feat_w;
  logic                    sat_acc, sat_out, sat_feat;

  assign pop_o = avail_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    sum_w   = SumW'(acc_q) + SumW'(entry_i.operand);
    sat_acc = 1'b0;
    acc_d   = acc_q;
    unique case (entry_i.op)
      OP_CLEAR: acc_d = '0;
      OP_ADD: begin
        if (sum_w > AccMax) begin
          acc_d   = ACC_WIDTH'(AccMax);
          sat_acc = 1'b1;
        end else if (sum_w < AccMin) begin
          acc_d   = ACC_WIDTH'(AccMin);
          sat_acc = 1'b1;
        end else begin
          acc_d   = ACC_WIDTH'(sum_w);
        end
      end
      default: acc_d = acc_q;
    endcase

    acc_x   = SumW'(acc_d);
    sat_out = 1'b0;
    if (acc_x > OutMaxX) begin
      genus_d = OUT_MAX;
      sat_out = 1'b1;
    end else if (acc_x < OutMinX) begin
      genus_d = ~OUT_MAX;
      sat_out = 1'b1;
    end else begin
      genus_d = OUT_W'(acc_x);
    end

    feat_w   = (OUT_W + 1)'(FEAT_BIAS) - (OUT_W + 1)'(genus_d);
    sat_feat = (feat_w > FeatMax);
    feature_d = sat_feat ? OUT_MAX : OUT_W'(feat_w);
    sat_d     = sat_acc || sat_out || sat_feat;

    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      genus_q   <= genus_d;
      feature_q <= feature_d;
      sat_q     <= sat_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign genus_quarters_o   = genus_q;
  assign feature_quarters_o = feature_q;
  assign saturated_o        = sat_q;

endmodule

// File: rtl/incremental_euler_number.sv
// Top level of the incremental Euler number block: front end, queue, accumulator.
// Depends on ien_pkg, ien_front, ien_queue, ien_back and the assertion macro header.
//
// Input channel: in_valid_i / in_stall_o with func_i (0 clear, 1 add pixel, 2 merge),
// neighbours_i (eight neighbour membership bits) and other_quarters_i (signed).
// Output channel: out_valid_o / out_stall_i with genus_quarters_o, feature_quarters_o
// (4 - genus) and saturated_o. A transaction moves on an edge where valid is high
// and stall is low. Every input transaction yields exactly one output transaction.
// The input is written into the queue and then into the registered result stage.
// Throughput: one transaction per cycle while the receiver does not stall, set by
// the accumulate in the back end; the front end decodes the pixel neighbourhood
// in the accept cycle. A two-entry queue separates the front end from the result
// register, so the input keeps being taken while a result waits; in_stall_o rises
// only when the queue is full.
// Reset clears the accumulator, empties the queue and drops out_valid_o.
// The accumulator is ACC_WIDTH bits and saturates; outputs clamp to 24 bits.
`include "incremental_euler_number_defines.svh"
module incremental_euler_number #(
  parameter int ACC_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ien_pkg::FUNC_W-1:0]       func_i,
  input  logic [ien_pkg::NB_W-1:0]         neighbours_i,
  input  logic signed [ien_pkg::OUT_W-1:0] other_quarters_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ien_pkg::OUT_W-1:0] genus_quarters_o,
  output logic signed [ien_pkg::OUT_W-1:0] feature_quarters_o,
  output logic                             saturated_o
);
  import ien_pkg::*;

  entry_t        front_entry;
  entry_t        queue_entry;
  queue_status_t q_status;
  logic          push;
  logic          pop;

  assign in_stall_o = q_status.full;
  assign push       = in_valid_i && !q_status.full;

  ien_front u_front (
    .func_i           (func_i),
    .neighbours_i     (neighbours_i),
    .other_quarters_i (other_quarters_i),
    .entry_o          (front_entry)
  );

  ien_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .entry_o  (queue_entry),
    .status_o (q_status)
  );

  ien_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .avail_i            (!q_status.empty),
    .entry_i            (queue_entry),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .genus_quarters_o   (genus_quarters_o),
    .feature_quarters_o (feature_quarters_o),
    .saturated_o        (saturated_o)
  );

  `IEN_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push, !q_status.empty)
  `IEN_ASSERT_NEXT(a_clear_zero, clk_i, rst_ni,
                   pop && queue_entry.op == OP_CLEAR,
                   genus_quarters_o == '0 && !saturated_o)
  `IEN_ASSERT_IMP(a_feature, clk_i, rst_ni,
                  out_valid_o && !saturated_o,
                  feature_quarters_o == FEAT_BIAS - genus_quarters_o)

endmodule

// File: sim/incremental_euler_number_tb.sv
// Testbench for incremental_euler_number: directed and random transactions with bursty
// input and a stalling receiver, each result checked against a bit-quad genus predictor.
// Depends on ien_pkg and the incremental_euler_number RTL.
`timescale 1ns / 100ps

module incremental_euler_number_tb;
  import ien_pkg::*;

  localparam int ACC_W = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic signed [OUT_W-1:0] genus;
    logic signed [OUT_W-1:0] feature;
    logic                    sat;
  } euler_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [FUNC_W-1:0]       func_i = FUNC_CLEAR;
  logic [NB_W-1:0]         neighbours_i = '0;
  logic signed [OUT_W-1:0] other_quarters_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] genus_quarters_o;
  logic signed [OUT_W-1:0] feature_quarters_o;
  logic                    saturated_o;

  euler_result_t expected_results[$];
  euler_result_t expected_r;
  longint        genus_acc_q = 0;
  int            mismatch_count = 0;
  int            burst_left = 0;
  bit            idle_en = 1'b0;
  bit            stall_en = 1'b0;
  int            stall_run = 0;
  bit            stall_hold = 1'b0;

  incremental_euler_number #(.ACC_WIDTH(ACC_W)) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .neighbours_i       (neighbours_i),
    .other_quarters_i   (other_quarters_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .genus_quarters_o   (genus_quarters_o),
    .feature_quarters_o (feature_quarters_o),
    .saturated_o        (saturated_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int quad_weight(logic [8:0] win);
    int   w;
    int   n;
    logic a, b, d, e;
    w = 0;
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        a = win[r*3 + c];
        b = win[r*3 + c + 1];
        d = win[(r+1)*3 + c];
        e = win[(r+1)*3 + c + 1];
        n = int'(a) + int'(b) + int'(d) + int'(e);
        if (n == 1) begin
          w += 1;
        end else if (n == 3) begin
          w -= 1;
        end else if (n == 2 && ((a && e) || (b && d))) begin
          w += 2;
        end
      end
    end
    return w;
  endfunction

  function automatic int neighbour_delta(logic [NB_W-1:0] nb);
    logic [8:0] win;
    win = {nb[7], nb[6], nb[5], nb[4], 1'b0, nb[3], nb[2], nb[1], nb[0]};
    return quad_weight(win | 9'b000010000) - quad_weight(win);
  endfunction

  function automatic euler_result_t predict_genus(logic [FUNC_W-1:0] f, logic [NB_W-1:0] nb,
                                                  logic signed [OUT_W-1:0] oq);
    euler_result_t res;
    longint        acc_hi;
    longint        acc_lo;
    longint        next_acc;
    longint        g;
    longint        fv;
    acc_hi = (longint'(1) <<< (ACC_W - 1)) - 1;
    acc_lo = -acc_hi - 1;
    res.sat = 1'b0;
    case (f)
      FUNC_CLEAR: next_acc = 0;
      FUNC_ADD:   next_acc = genus_acc_q + neighbour_delta(nb);
      FUNC_MERGE: next_acc = genus_acc_q + longint'(oq);
      default:    next_acc = genus_acc_q;
    endcase
    if (next_acc > acc_hi) begin
      next_acc = acc_hi;
      res.sat = 1'b1;
    end else if (next_acc < acc_lo) begin
      next_acc = acc_lo;
      res.sat = 1'b1;
    end
    genus_acc_q = next_acc;
    g = next_acc;
    if (g > 64'sd8388607) begin
      g = 64'sd8388607;
      res.sat = 1'b1;
    end else if (g < -64'sd8388608) begin
      g = -64'sd8388608;
      res.sat = 1'b1;
    end
    fv = 4 - g;
    if (fv > 64'sd8388607) begin
      fv = 64'sd8388607;
      res.sat = 1'b1;
    end else if (fv < -64'sd8388608) begin
      fv = -64'sd8388608;
      res.sat = 1'b1;
    end
    res.genus = OUT_W'(g);
    res.feature = OUT_W'(fv);
    return res;
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got genus %0d feature %0d sat %0b",
                 $time, genus_quarters_o, feature_quarters_o, saturated_o);
        mismatch_count++;
      end else begin
        expected_r = expected_results.pop_front();
        check_field("genus_quarters", longint'(expected_r.genus), longint'(genus_quarters_o));
        check_field("feature_quarters", longint'(expected_r.feature),
                    longint'(feature_quarters_o));
        check_field("saturated", longint'(expected_r.sat), longint'(saturated_o));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results.push_back(predict_genus(func_i, neighbours_i, other_quarters_i));
    end
  end

  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, 8);
      stall_hold = stall_en && ($urandom_range(0, 2) == 0);
    end
    stall_run--;
    out_stall_i <= stall_hold;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("incremental_euler_number: mismatch");
    $finish;
  end

  task automatic send_txn(logic [FUNC_W-1:0] f, logic [NB_W-1:0] nb,
                          logic signed [OUT_W-1:0] oq);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = idle_en ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    func_i <= f;
    neighbours_i <= nb;
    other_quarters_i <= oq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(int big_merge_pct);
    int                      pick;
    logic signed [OUT_W-1:0] oq;
    pick = $urandom_range(0, 99);
    oq = OUT_W'($urandom);
    if (pick < 3) begin
      send_txn(FUNC_CLEAR, NB_W'($urandom), oq);
    end else if (pick < 5) begin
      send_txn(FUNC_UNUSED, NB_W'($urandom), oq);
    end else if (pick < 15) begin
      if ($urandom_range(0, 99) >= big_merge_pct) begin
        oq = OUT_W'(int'($urandom_range(0, 64)) - 32);
      end
      send_txn(FUNC_MERGE, NB_W'($urandom), oq);
    end else begin
      send_txn(FUNC_ADD, NB_W'($urandom), oq);
    end
  endtask

  task automatic test_directed_cases();
    idle_en = 1'b0;
    stall_en = 1'b0;
    send_txn(FUNC_CLEAR, 8'hFF, 24'sh7FFFFF);
    send_txn(FUNC_ADD, 8'h00, 24'sh000000);
    send_txn(FUNC_ADD, 8'hFF, 24'sh000000);
    send_txn(FUNC_ADD, 8'h55, 24'sh000000);
    send_txn(FUNC_ADD, 8'hAA, 24'sh000000);
    send_txn(FUNC_ADD, 8'h81, 24'sh000000);
    send_txn(FUNC_ADD, 8'h24, 24'sh000000);
    send_txn(FUNC_ADD, 8'h5A, 24'sh000000);
    send_txn(FUNC_ADD, 8'h0A, 24'sh000000);
    send_txn(FUNC_UNUSED, 8'hFF, 24'sh7FFFFF);
    send_txn(FUNC_MERGE, 8'h00, 24'sh7FFFFF);
    send_txn(FUNC_ADD, 8'h00, 24'sh000000);
    send_txn(FUNC_MERGE, 8'h00, -24'sh000001);
    send_txn(FUNC_CLEAR, 8'h00, 24'sh000000);
    send_txn(FUNC_MERGE, 8'h00, 24'sh800000);
    send_txn(FUNC_MERGE, 8'h00, -24'sh000001);
    send_txn(FUNC_ADD, 8'hFF, 24'sh000000);
    send_txn(FUNC_CLEAR, 8'h00, 24'sh000000);
    send_txn(FUNC_MERGE, 8'h00, -24'sd8388604);
    send_txn(FUNC_MERGE, 8'h00, 24'sh000001);
    send_txn(FUNC_CLEAR, 8'h00, 24'sh000000);
    send_txn(FUNC_MERGE, 8'h00, 24'sh7FFFFB);
    send_txn(FUNC_MERGE, 8'h00, 24'sh000004);
    send_txn(FUNC_CLEAR, 8'h00, 24'sh000000);
  endtask

  task automatic test_streaming_random();
    idle_en = 1'b0;
    stall_en = 1'b0;
    repeat (350) send_random(20);
    stall_en = 1'b1;
    repeat (150) send_random(20);
  endtask

  task automatic test_bursty_random();
    idle_en = 1'b1;
    stall_en = 1'b1;
    repeat (700) send_random(10);
  endtask

  task automatic test_saturation_random();
    idle_en = 1'b1;
    stall_en = 1'b1;
    repeat (330) send_random(80);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_streaming_random();
    test_bursty_random();
    test_saturation_random();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("incremental_euler_number: match");
    end else begin
      $display("incremental_euler_number: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ien_pkg.sv
rtl/ien_front.sv
rtl/ien_queue.sv
rtl/ien_back.sv
rtl/incremental_euler_number.sv
sim/incremental_euler_number_tb.sv
